/* hdl/stbs_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the sorted table binary search core.
// Depends on nothing; every other file of the block imports it.
package stbs_pkg;

  localparam int DEFAULT_TABLE_DEPTH   = 1024;
  localparam int DEFAULT_KEY_PART_BITS = 16;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_PROBE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic write_entry;
    logic start;
    logic setup;
    logic step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic setup_empty;
    logic hit;
    logic step_empty;
  } sts_t;

endpackage

/* hdl/stbs_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine of the binary search core.
// Depends on stbs_pkg; drives the datapath through cmd_t and reads sts_t.
module stbs_ctrl
  import stbs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_op,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && (in_op == OP_SEARCH)) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_nxt = sts.setup_empty ? ST_FINISH : ST_PROBE;
      end
      ST_PROBE: begin
        if (sts.hit || sts.step_empty) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    in_ready    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready        = 1'b1;
        cmd.write_entry = in_valid && (in_op == OP_WRITE);
        cmd.start       = in_valid && (in_op == OP_SEARCH);
      end
      ST_SETUP:  cmd.setup    = 1'b1;
      ST_PROBE:  cmd.step     = 1'b1;
      ST_FINISH: cmd.load_out = out_free;
      default:   cmd          = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* hdl/stbs_datapath.sv */
`timescale 1ns / 1ps
// Datapath of the binary search core: entry memory, range registers and result.
// Depends on stbs_pkg; commanded by stbs_ctrl.
module stbs_datapath
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH   = DEFAULT_TABLE_DEPTH,
  parameter int KEY_PART_BITS = DEFAULT_KEY_PART_BITS,
  localparam int IDX_W        = $clog2(TABLE_DEPTH),
  localparam int CNT_W        = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CNT_W-1:0]         cfg_data,
  input  logic [IDX_W-1:0]         in_entry_index,
  input  logic [KEY_PART_BITS-1:0] in_key_high,
  input  logic [KEY_PART_BITS-1:0] in_key_low,
  input  logic                     in_mark_in,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  output logic                     out_found,
  output logic                     out_needs_action
);

  localparam int KEY_W = 2 * KEY_PART_BITS;
  localparam int ENT_W = KEY_W + 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  logic [ENT_W-1:0] mem [TABLE_DEPTH];
  logic [ENT_W-1:0] rd_data_r;
  logic [IDX_W-1:0] rd_addr;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] lo_r, lo_nxt;
  logic [CNT_W-1:0] hi_r, hi_nxt;
  logic [IDX_W-1:0] mid_r, mid_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic             res_found_r, res_found_nxt;
  logic             res_need_r, res_need_nxt;
  logic             out_found_r, out_need_r;

  logic [CNT_W-1:0] count_sat;
  logic [CNT_W-1:0] mid_cur_full;
  logic [IDX_W-1:0] mid_cur;
  logic [KEY_W-1:0] probe_key;
  logic             probe_mark;
  logic             probe_eq, probe_gt;
  logic [CNT_W-1:0] lo_step, hi_step;
  logic [CNT_W-1:0] mid_step_full;
  logic [IDX_W-1:0] mid_step;
  logic             wr_in_range;

  assign count_sat    = (count_r > DEPTH_C) ? DEPTH_C : count_r;
  assign mid_cur_full = lo_r + ((hi_r - lo_r) >> 1);
  assign mid_cur      = mid_cur_full[IDX_W-1:0];

  assign probe_key  = rd_data_r[ENT_W-1:1];
  assign probe_mark = rd_data_r[0];
  assign probe_eq   = (probe_key == key_r);
  assign probe_gt   = (probe_key > key_r);

  assign lo_step       = probe_gt ? lo_r : (CNT_W'(mid_r) + CNT_W'(1));
  assign hi_step       = probe_gt ? CNT_W'(mid_r) : hi_r;
  assign mid_step_full = lo_step + ((hi_step - lo_step) >> 1);
  assign mid_step      = mid_step_full[IDX_W-1:0];

  assign rd_addr = cmd.setup ? mid_cur : mid_step;

  assign sts.setup_empty = !(lo_r < hi_r);
  assign sts.hit         = probe_eq;
  assign sts.step_empty  = !(lo_step < hi_step);

  assign wr_in_range = (CNT_W'(in_entry_index) < DEPTH_C);

  always_ff @(posedge clk) begin
    if (cmd.write_entry && wr_in_range) begin
      mem[in_entry_index] <= {in_key_high, in_key_low, in_mark_in};
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    count_nxt     = cfg_we ? cfg_data : count_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    key_nxt       = key_r;
    res_found_nxt = res_found_r;
    res_need_nxt  = res_need_r;
    if (cmd.start) begin
      lo_nxt        = '0;
      hi_nxt        = count_sat;
      key_nxt       = {in_key_high, in_key_low};
      res_found_nxt = 1'b0;
      res_need_nxt  = 1'b1;
    end
    if (cmd.setup) begin
      mid_nxt = mid_cur;
    end
    if (cmd.step) begin
      lo_nxt  = lo_step;
      hi_nxt  = hi_step;
      mid_nxt = mid_step;
      if (probe_eq) begin
        res_found_nxt = 1'b1;
        res_need_nxt  = !probe_mark;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= CNT_W'(1);
      lo_r        <= '0;
      hi_r        <= '0;
      key_r       <= '0;
      res_found_r <= 1'b0;
      res_need_r  <= 1'b1;
    end else begin
      count_r     <= count_nxt;
      lo_r        <= lo_nxt;
      hi_r        <= hi_nxt;
      key_r       <= key_nxt;
      res_found_r <= res_found_nxt;
      res_need_r  <= res_need_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mid_r <= mid_nxt;
    if (cmd.load_out) begin
      out_found_r <= res_found_r;
      out_need_r  <= res_need_r;
    end
  end

  assign out_found        = out_found_r;
  assign out_needs_action = out_need_r;

endmodule

/* hdl/sorted_table_binary_search_core.sv */
`timescale 1ns / 1ps
// Sorted table binary search core: an entry memory with a search controller.
// A write transaction stores one entry and the block is ready again at once.
// A search transaction, once accepted, passes through a setup state that sets up the range,
// then a probe state that reads the entry memory once per step (at most floor(log2(n)) + 1
// probes for n entries, eleven for 1024), then a finish state that loads the answer, after
// which the block returns to idle and takes the next transaction. An empty range skips the
// probes. The single read port returns its data registered. The finish state is held for
// as long as an earlier answer waits on out_ready. The table must be written in ascending
// key order, and entries beyond the configured count are never probed. There is no
// clearing pass after reset.
module sorted_table_binary_search_core
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH   = DEFAULT_TABLE_DEPTH,
  parameter int KEY_PART_BITS = DEFAULT_KEY_PART_BITS,
  localparam int IDX_W        = $clog2(TABLE_DEPTH),
  localparam int CNT_W        = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CNT_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_op,
  input  logic [IDX_W-1:0]         in_entry_index,
  input  logic [KEY_PART_BITS-1:0] in_key_high,
  input  logic [KEY_PART_BITS-1:0] in_key_low,
  input  logic                     in_mark_in,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_found,
  output logic                     out_needs_action
);

  cmd_t cmd;
  sts_t sts;

  stbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  stbs_datapath #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .KEY_PART_BITS (KEY_PART_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .in_entry_index   (in_entry_index),
    .in_key_high      (in_key_high),
    .in_key_low       (in_key_low),
    .in_mark_in       (in_mark_in),
    .cmd              (cmd),
    .sts              (sts),
    .out_found        (out_found),
    .out_needs_action (out_needs_action)
  );

endmodule

/* hdl/stbs_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the sorted table binary search core, with its bind statement.
// Depends on stbs_pkg and on the port names of sorted_table_binary_search_core.
module stbs_checker
  import stbs_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_op,
  input logic out_valid,
  input logic out_ready,
  input logic out_found,
  input logic out_needs_action
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found) && $stable(out_needs_action))
    else $error("Result changed or vanished while stalled.");

  a_miss_needs_action: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_found || out_needs_action))
    else $error("A missing key was reported as needing no action.");

  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == OP_SEARCH) |=> !in_ready)
    else $error("Input taken while a search was starting.");

  a_write_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == OP_WRITE) |=> in_ready)
    else $error("Block stalled after a write transaction.");

endmodule

bind sorted_table_binary_search_core stbs_checker u_stbs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_op            (in_op),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_found        (out_found),
  .out_needs_action (out_needs_action)
);
